### hw/rtl/i2a_pkg.sv
// Shared constants, types and helper functions of the integer-to-ASCII formatter.
package i2a_pkg;

	// Value and field sizes.
	localparam int VALUE_BITS = 32;
	localparam int MAX_WIDTH  = 48;
	localparam int MAG_W      = 32;
	localparam int FW_W       = 6;

	// Helper for elaboration-time sizing.
	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// Digit counts of the largest value in each radix.
	localparam int BIN_DIG = VALUE_BITS;
	localparam int OCT_DIG = (VALUE_BITS + 2) / 3;
	localparam int HEX_DIG = (VALUE_BITS + 3) / 4;
	localparam int DEC_DIG = (VALUE_BITS * 30103 + 99999) / 100000;
	localparam int BCD_W   = 4 * DEC_DIG;

	// The digit shift register holds the most significant digit in its top bits.
	localparam int DREG_W  = imax(imax(BIN_DIG, 3 * OCT_DIG), imax(BCD_W, 4 * HEX_DIG));
	localparam int MAX_DIG = BIN_DIG;
	localparam int DIG_W   = $clog2(MAX_DIG + 1);
	localparam int LEN_MAX = imax(MAX_WIDTH, MAX_DIG + 1);
	localparam int LEN_W   = $clog2(LEN_MAX + 1);
	localparam int MAGX_W  = imax(MAG_W, VALUE_BITS);
	localparam int CNT_W   = $clog2(VALUE_BITS + 1);

	// Alignment shifts that put the top digit slot at the top of the register.
	localparam int SH_BIN = DREG_W - BIN_DIG;
	localparam int SH_OCT = DREG_W - 3 * OCT_DIG;
	localparam int SH_HEX = DREG_W - 4 * HEX_DIG;
	localparam int SH_DEC = DREG_W - BCD_W;

	// Radix codes.
	localparam logic [1:0] RADIX_BIN = 2'd0;
	localparam logic [1:0] RADIX_OCT = 2'd1;
	localparam logic [1:0] RADIX_DEC = 2'd2;
	localparam logic [1:0] RADIX_HEX = 2'd3;

	// Character codes.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UPPER = 8'h41;
	localparam logic [7:0] CH_LOWER = 8'h61;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [3:0] DEC_BASE = 4'd10;

	// One formatting job handed from the front end to the emitter.
	typedef struct packed {
		logic [DREG_W-1:0] digits;
		logic [1:0]        radix;
		logic [DIG_W-1:0]  ndig;
		logic              neg;
		logic [LEN_W-1:0]  width;
		logic              left;
		logic              zero;
		logic              upper;
	} i2a_job_t;

	// ASCII character of one digit.
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		if (d < DEC_BASE) begin
			return CH_ZERO + {4'd0, d};
		end
		base = upper ? CH_UPPER : CH_LOWER;
		return base + {4'd0, d - DEC_BASE};
	endfunction

endpackage

### hw/rtl/i2a_bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one value bit per cycle.
module i2a_bcd import i2a_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  done,
	output logic [BCD_W-1:0]      bcd
);

	logic [VALUE_BITS-1:0] val_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      adj;
	logic [CNT_W-1:0]      cnt_q;
	logic                  run_q;
	logic                  done_q;

	// Add three to every BCD digit of five or more before the shift.
	always_comb begin
		for (int i = 0; i < DEC_DIG; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Shift one value bit into the BCD digits per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q  <= '0;
			bcd_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (start) begin
				val_q  <= value;
				bcd_q  <= '0;
				cnt_q  <= '0;
				run_q  <= 1'b1;
				done_q <= 1'b0;
			end else if (run_q) begin
				{bcd_q, val_q} <= {adj[BCD_W-2:0], val_q, 1'b0};
				cnt_q  <= cnt_q + 1'b1;
				done_q <= (cnt_q == CNT_W'(VALUE_BITS - 1));
				if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
					run_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

### hw/rtl/i2a_emit.sv
// Digit-serial emitter: strips leading zeros, then sends padding, sign and digits.
module i2a_emit import i2a_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  i2a_job_t   job,
	output logic       busy,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast
);

	typedef enum logic [1:0] {E_IDLE, E_NORM, E_SIZE, E_SEND} state_t;

	state_t            state_q;
	logic [DREG_W-1:0] digits_q;
	logic [DREG_W-1:0] digits_shl;
	logic [1:0]        radix_q;
	logic [DIG_W-1:0]  ndig_q;
	logic              sign_q;
	logic [LEN_W-1:0]  width_q;
	logic              left_q;
	logic              zero_q;
	logic              upper_q;
	logic [LEN_W-1:0]  pad_q;
	logic [LEN_W-1:0]  rem_q;
	logic              tvalid_q;
	logic [7:0]        tdata_q;
	logic              tlast_q;
	logic [3:0]        top4;
	logic [3:0]        digit;
	logic [LEN_W-1:0]  nsig;
	logic [LEN_W-1:0]  len;
	logic              out_free;
	logic              pick_sign;
	logic              pick_pad;
	logic [7:0]        pad_char;
	logic [7:0]        next_char;

	// Most significant digit and the register shifted past it.
	assign top4 = digits_q[DREG_W-1 -: 4];
	always_comb begin
		case (radix_q)
			RADIX_BIN: begin
				digit      = {3'd0, top4[3]};
				digits_shl = digits_q << 1;
			end
			RADIX_OCT: begin
				digit      = {1'b0, top4[3:1]};
				digits_shl = digits_q << 3;
			end
			default: begin
				digit      = top4;
				digits_shl = digits_q << 4;
			end
		endcase
	end

	// Text length from the digit count, sign and field width.
	assign nsig = LEN_W'(ndig_q) + LEN_W'(sign_q);
	assign len  = (width_q > nsig) ? width_q : nsig;

	// Choose the next character from the layout and what is left to send.
	always_comb begin
		pad_char = CH_SPACE;
		if (left_q) begin
			pick_sign = sign_q;
			pick_pad  = !sign_q && (ndig_q == '0);
		end else if (zero_q) begin
			pick_sign = sign_q;
			pick_pad  = !sign_q && (pad_q != '0);
			pad_char  = CH_ZERO;
		end else begin
			pick_pad  = (pad_q != '0);
			pick_sign = !pick_pad && sign_q;
		end
		if (pick_sign) begin
			next_char = CH_MINUS;
		end else if (pick_pad) begin
			next_char = pad_char;
		end else begin
			next_char = digit_char(digit, upper_q);
		end
	end

	assign out_free = !tvalid_q || m_tready;

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= E_IDLE;
			digits_q <= '0;
			radix_q  <= RADIX_BIN;
			ndig_q   <= '0;
			sign_q   <= 1'b0;
			width_q  <= '0;
			left_q   <= 1'b0;
			zero_q   <= 1'b0;
			upper_q  <= 1'b0;
			pad_q    <= '0;
			rem_q    <= '0;
			tvalid_q <= 1'b0;
			tdata_q  <= '0;
			tlast_q  <= 1'b0;
		end else begin
			// While sending, the send branch below refills the output register.
			if (tvalid_q && m_tready && (state_q != E_SEND)) begin
				tvalid_q <= 1'b0;
			end
			case (state_q)
				E_IDLE: begin
					if (go) begin
						digits_q <= job.digits;
						radix_q  <= job.radix;
						ndig_q   <= job.ndig;
						sign_q   <= job.neg;
						width_q  <= job.width;
						left_q   <= job.left;
						zero_q   <= job.zero;
						upper_q  <= job.upper;
						state_q  <= E_NORM;
					end
				end
				E_NORM: begin
					// Drop one leading zero digit per cycle, keeping at least one.
					if (ndig_q > DIG_W'(1) && digit == 4'd0) begin
						digits_q <= digits_shl;
						ndig_q   <= ndig_q - 1'b1;
					end else begin
						state_q <= E_SIZE;
					end
				end
				E_SIZE: begin
					pad_q   <= len - nsig;
					rem_q   <= len;
					state_q <= E_SEND;
				end
				E_SEND: begin
					if (out_free) begin
						tvalid_q <= 1'b1;
						tdata_q  <= next_char;
						tlast_q  <= (rem_q == LEN_W'(1));
						rem_q    <= rem_q - 1'b1;
						if (pick_sign) begin
							sign_q <= 1'b0;
						end else if (pick_pad) begin
							if (pad_q != '0) begin
								pad_q <= pad_q - 1'b1;
							end
						end else begin
							digits_q <= digits_shl;
							ndig_q   <= ndig_q - 1'b1;
						end
						if (rem_q == LEN_W'(1)) begin
							state_q <= E_IDLE;
						end
					end
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != E_IDLE);
	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tlast  = tlast_q;

endmodule

### hw/rtl/integer_to_ascii_formatter.sv
// Top level of the integer-to-ASCII formatter: request capture and digit preparation.
//
// Usage: a request enters on the s_ stream (s_tvalid, s_tready, s_tdata) and
// holds a magnitude, a radix code, a minus flag, a field width and the
// left-adjust, zero-pad and upper-case flags. The formatted text leaves on the
// m_ stream one ASCII character per transfer, most significant first, with
// m_tlast on the final character.
// Throughput: one request is worked on at a time. For binary, octal and hex the
// next request can be taken once the previous one has been stripped of leading
// zeros, sized and sent; decimal first adds the bit-serial BCD conversion. The
// leading zero strip runs one digit a cycle and the output sends one character
// a cycle while the receiver is ready.
// s_tready is high only while no request is in progress; the last character
// may still wait in the output register when the next request is taken.
// Reset clears all control state; no request or character is pending after it.
// When the receiver stalls, the current character holds in the output register
// and character generation pauses until m_tready returns.
module integer_to_ascii_formatter import i2a_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// magnitude[31:0], radix_code[33:32], minus[34], field_width[40:35],
	// left_adjust[41], zero_pad[42], upper_case[43], zeros[47:44]
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// text_byte[7:0]
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);

	typedef enum logic {T_IDLE, T_CONV} state_t;

	state_t                state_q;
	i2a_job_t              job_q;
	logic                  go_q;
	logic                  accept;
	logic [MAGX_W-1:0]     magx;
	logic [VALUE_BITS-1:0] value;
	logic [1:0]            radix;
	logic [FW_W-1:0]       fw;
	logic [LEN_W-1:0]      width_sat;
	logic [DREG_W-1:0]     aligned;
	logic [DIG_W-1:0]      ndig_max;
	logic                  bcd_done;
	logic [BCD_W-1:0]      bcd;
	logic                  emit_busy;

	localparam int CMP_W = imax(FW_W, LEN_W);

	assign s_tready = (state_q == T_IDLE) && !go_q && !emit_busy;
	assign accept   = s_tvalid && s_tready;

	// Request fields.
	assign magx  = MAGX_W'(s_tdata[31:0]);
	assign value = magx[VALUE_BITS-1:0];
	assign radix = s_tdata[33:32];
	assign fw    = s_tdata[40:35];

	// Field width limited to the largest supported width.
	always_comb begin
		if (CMP_W'(fw) > CMP_W'(MAX_WIDTH)) begin
			width_sat = LEN_W'(MAX_WIDTH);
		end else begin
			width_sat = LEN_W'(fw);
		end
	end

	// Power-of-two radices take their digits straight from the value bits.
	always_comb begin
		case (radix)
			RADIX_BIN: begin
				aligned  = DREG_W'(value) << SH_BIN;
				ndig_max = DIG_W'(BIN_DIG);
			end
			RADIX_OCT: begin
				aligned  = DREG_W'(value) << SH_OCT;
				ndig_max = DIG_W'(OCT_DIG);
			end
			RADIX_HEX: begin
				aligned  = DREG_W'(value) << SH_HEX;
				ndig_max = DIG_W'(HEX_DIG);
			end
			default: begin
				aligned  = '0;
				ndig_max = DIG_W'(DEC_DIG);
			end
		endcase
	end

	// Capture the request and hand it to the emitter, after BCD conversion for decimal.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			job_q   <= '0;
			go_q    <= 1'b0;
		end else begin
			case (state_q)
				T_IDLE: begin
					go_q <= accept && (radix != RADIX_DEC);
					if (accept) begin
						job_q.digits <= aligned;
						job_q.radix  <= radix;
						job_q.ndig   <= ndig_max;
						job_q.neg    <= s_tdata[34];
						job_q.width  <= width_sat;
						job_q.left   <= s_tdata[41];
						job_q.zero   <= s_tdata[42];
						job_q.upper  <= s_tdata[43];
						if (radix == RADIX_DEC) begin
							state_q <= T_CONV;
						end
					end
				end
				T_CONV: begin
					go_q <= bcd_done;
					if (bcd_done) begin
						job_q.digits <= DREG_W'(bcd) << SH_DEC;
						state_q      <= T_IDLE;
					end
				end
				default: begin
					go_q    <= 1'b0;
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	i2a_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && (radix == RADIX_DEC)),
		.value  (value),
		.done   (bcd_done),
		.bcd    (bcd)
	);

	i2a_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go_q),
		.job      (job_q),
		.busy     (emit_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

### tb/sv/integer_to_ascii_formatter_test.sv
// Self-checking testbench of the integer-to-ASCII formatter with a text predictor.
`timescale 1ns / 100ps

module integer_to_ascii_formatter_test import i2a_pkg::*;;

	// One character of formatted text as it leaves the block.
	typedef struct {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	// Predicts the text of each accepted request and checks the characters against it.
	class text_predictor;
		text_char_t expected_text[$];
		int         mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Render one request into the queue of expected characters.
		function void note_request(input logic [47:0] req);
			logic [31:0] mag;
			logic [31:0] base;
			logic        neg;
			logic        left;
			logic        zero;
			logic        upper;
			logic [7:0]  digits[$];
			logic [7:0]  line[$];
			int          width;
			int          nsig;
			int          len;
			int          pad;
			int          d;
			text_char_t  c;

			mag   = req[31:0];
			neg   = req[34];
			width = int'(req[40:35]);
			left  = req[41];
			zero  = req[42];
			upper = req[43];
			case (req[33:32])
				RADIX_BIN: base = 2;
				RADIX_OCT: base = 8;
				RADIX_DEC: base = 10;
				default:   base = 16;
			endcase
			if (width > MAX_WIDTH) width = MAX_WIDTH;

			// Digits come out least significant first, so build the string from the front.
			do begin
				d = int'(mag % base);
				if (d < 10)
					digits.push_front(CH_ZERO + 8'(d));
				else
					digits.push_front((upper ? CH_UPPER : CH_LOWER) + 8'(d - 10));
				mag = mag / base;
			end while (mag != 0);

			nsig = digits.size() + int'(neg);
			len  = (width > nsig) ? width : nsig;
			pad  = len - nsig;

			// Left adjusted ignores zero padding; zero padding keeps the sign in front.
			if (left) begin
				if (neg) line.push_back(CH_MINUS);
				foreach (digits[i]) line.push_back(digits[i]);
				repeat (pad) line.push_back(CH_SPACE);
			end else if (zero) begin
				if (neg) line.push_back(CH_MINUS);
				repeat (pad) line.push_back(CH_ZERO);
				foreach (digits[i]) line.push_back(digits[i]);
			end else begin
				repeat (pad) line.push_back(CH_SPACE);
				if (neg) line.push_back(CH_MINUS);
				foreach (digits[i]) line.push_back(digits[i]);
			end

			foreach (line[i]) begin
				c.ch   = line[i];
				c.last = (i == line.size() - 1);
				expected_text.push_back(c);
			end
		endfunction

		// Compare one delivered character with the oldest expected one.
		function void check_char(input logic [7:0] ch, input logic last);
			text_char_t want;

			if (expected_text.size() == 0) begin
				$display("%0t: unexpected character, expected none, actual %h last %b",
					$time, ch, last);
				mismatches++;
				return;
			end
			want = expected_text.pop_front();
			if (ch !== want.ch) begin
				$display("%0t: text_byte mismatch, expected %h, actual %h", $time, want.ch, ch);
				mismatches++;
			end
			if (last !== want.last) begin
				$display("%0t: last_byte mismatch, expected %b, actual %b",
					$time, want.last, last);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_text.size();
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	text_predictor predictor = new();
	bit            idle_on   = 1'b1;
	int            stall_left = 0;

	integer_to_ascii_formatter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Idle length: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;

		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Present one request and hold it until the block takes it.
	task automatic send_request(input logic [31:0] mag, input logic [1:0] radix,
			input logic neg, input logic [5:0] fw, input logic left,
			input logic zero, input logic upper);
		int gap;

		s_tdata  <= {4'd0, upper, zero, left, fw, neg, radix, mag};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predictor.note_request(s_tdata);
		@(negedge clk);
		gap = idle_on ? gap_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Random request, biased toward short values and edge magnitudes.
	task automatic send_random_request();
		logic [31:0] mag;
		logic [5:0]  fw;

		case ($urandom_range(0, 5))
			0: mag = $urandom_range(0, 15);
			1: mag = $urandom_range(0, 999);
			2: mag = 32'hFFFF_FFFF >> $urandom_range(0, 31);
			3: mag = 32'd1 << $urandom_range(0, 31);
			default: mag = $urandom();
		endcase
		if ($urandom_range(0, 99) < 85)
			fw = 6'($urandom_range(0, MAX_WIDTH));
		else
			fw = 6'($urandom_range(MAX_WIDTH + 1, 63));
		send_request(mag, 2'($urandom_range(0, 3)), 1'($urandom()), fw,
			1'($urandom()), 1'($urandom()), 1'($urandom()));
	endtask

	// Receiver side: random stalls while idling is on.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if (idle_on && $urandom_range(0, 99) < 30) stall_left = gap_len();
		end
	end

	// Every delivered character is checked at the edge that moves it.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) predictor.check_char(m_tdata, m_tlast);
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests: zero, full-scale values, width saturation and every layout.
		send_request(32'd0, RADIX_BIN, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0);
		send_request(32'd0, RADIX_DEC, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0);
		send_request(32'd0, RADIX_HEX, 1'b0, 6'd5, 1'b0, 1'b1, 1'b0);
		send_request(32'hFFFF_FFFF, RADIX_BIN, 1'b1, 6'd48, 1'b0, 1'b1, 1'b0);
		send_request(32'hFFFF_FFFF, RADIX_BIN, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0);
		send_request(32'hFFFF_FFFF, RADIX_OCT, 1'b0, 6'd63, 1'b0, 1'b0, 1'b0);
		send_request(32'hFFFF_FFFF, RADIX_DEC, 1'b0, 6'd10, 1'b0, 1'b0, 1'b1);
		send_request(32'hFFFF_FFFF, RADIX_HEX, 1'b0, 6'd4, 1'b0, 1'b0, 1'b0);
		send_request(32'hFFFF_FFFF, RADIX_HEX, 1'b1, 6'd12, 1'b1, 1'b1, 1'b1);
		send_request(32'hDEAD_BEEF, RADIX_HEX, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0);
		send_request(32'hABCD_EF01, RADIX_HEX, 1'b1, 6'd20, 1'b0, 1'b1, 1'b1);
		send_request(32'd1234567890, RADIX_DEC, 1'b1, 6'd20, 1'b0, 1'b1, 1'b0);
		send_request(32'd12345, RADIX_DEC, 1'b1, 6'd48, 1'b1, 1'b0, 1'b0);
		send_request(32'd12345, RADIX_DEC, 1'b1, 6'd49, 1'b0, 1'b0, 1'b0);
		send_request(32'd8, RADIX_OCT, 1'b0, 6'd3, 1'b1, 1'b0, 1'b0);
		send_request(32'd5, RADIX_BIN, 1'b0, 6'd63, 1'b1, 1'b1, 1'b1);
		send_request(32'h8000_0000, RADIX_BIN, 1'b0, 6'd1, 1'b0, 1'b0, 1'b0);
		send_request(32'd7, RADIX_OCT, 1'b1, 6'd2, 1'b0, 1'b1, 1'b0);
		send_request(32'd42, RADIX_DEC, 1'b1, 6'd6, 1'b0, 1'b0, 1'b0);
		send_request(32'hA, RADIX_HEX, 1'b0, 6'd1, 1'b0, 1'b0, 1'b0);

		// Random requests in phases, one of them without any idling.
		for (int phase = 0; phase < 4; phase++) begin
			idle_on = (phase != 1);
			repeat (35) send_random_request();
		end

		// Drain the remaining text, then give stray characters a chance to show.
		s_tvalid <= 1'b0;
		idle_on = 1'b0;
		while (predictor.pending() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (predictor.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Hard limit on the run.
	initial begin
		#15ms;
		$display("simulation failed");
		$finish;
	end

endmodule
